// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define AST_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define AST_IMP(lbl, clk, rstn, a, c)
`define AST_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== hw/rtl/izd_pkg.sv =====
// ----------------------------------------------------------------------------
// izd_pkg
// Shared constants and types for the irrigation zone decision block.
// ----------------------------------------------------------------------------
`default_nettype none
package izd_pkg;
  localparam int Sensors    = 4;
  localparam int PsiMin     = 0;
  localparam int PsiMax     = 2000;
  localparam int MaxRuntime = 7200;
  localparam int DivW       = 34;  // dividend width (acc 24b, depth 33b)
  localparam int DsrW       = 22;  // divisor width (36*65535 < 2^22)

  localparam logic [1:0] ModeManual = 2'd0;
  localparam logic [1:0] ModeFull   = 2'd2;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIrrig = 2'd1;
  localparam logic [1:0] StFault = 2'd2;

  localparam logic [2:0] RsNone    = 3'd0;
  localparam logic [2:0] RsFault   = 3'd1;
  localparam logic [2:0] RsManual  = 3'd2;
  localparam logic [2:0] RsStart   = 3'd3;
  localparam logic [2:0] RsSoil    = 3'd4;
  localparam logic [2:0] RsEt      = 3'd5;
  localparam logic [2:0] RsRuntime = 3'd6;

  localparam logic [2:0] RegMad  = 3'd0;
  localparam logic [2:0] RegFlow = 3'd1;
  localparam logic [2:0] RegArea = 3'd2;
  localparam logic [2:0] RegMode = 3'd3;
  localparam logic [2:0] RegW0   = 3'd4;  // weights 0..3 at RegW0..RegW0+3

  typedef struct packed {
    logic        valid;
    logic [11:0] psi;
    logic [21:0] prod;
  } lane_t;

  // per-item context carried along the divider pipe
  typedef struct packed {
    logic        fault;
    logic [1:0]  mode;
    logic [11:0] mad;
    logic [15:0] et;
    logic [16:0] elapsed;
    logic        depth_en;
  } ctx_t;
endpackage
`default_nettype wire

// ===== hw/rtl/izd_lane.sv =====
// ----------------------------------------------------------------------------
// izd_lane
// One sensor lane: range check and weighted product.
// ----------------------------------------------------------------------------
`default_nettype none
module izd_lane (
  input  wire logic [15:0]    psi_i,
  input  wire logic [9:0]     weight_i,
  output izd_pkg::lane_t      lane_o
);
  logic signed [16:0] p_s;
  assign p_s = 17'(signed'(psi_i));
  always_comb begin
    lane_o.valid = (p_s >= 17'(izd_pkg::PsiMin)) && (p_s <= 17'(izd_pkg::PsiMax));
    lane_o.psi   = psi_i[11:0];
    lane_o.prod  = 22'(psi_i[11:0]) * 22'(weight_i);
  end
endmodule
`default_nettype wire

// ===== hw/rtl/izd_div.sv =====
// ----------------------------------------------------------------------------
// izd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module izd_div (
  input  wire logic                       clk_i,
  input  wire logic [izd_pkg::DivW-1:0]   num_i,
  input  wire logic [izd_pkg::DsrW-1:0]   den_i,
  output logic      [izd_pkg::DivW-1:0]   quo_o
);
  localparam int W = izd_pkg::DivW;
  localparam int R = izd_pkg::DsrW + 1;
  logic [W-1:0] num_q [W+1];
  logic [R-1:0] rem_q [W+1];
  logic [R-2:0] den_q [W+1];

  always_comb begin
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [R-1:0] sh;
    logic [R-1:0] df;
    assign sh = {rem_q[s][R-2:0], num_q[s][W-1]};
    assign df = sh - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      if (!df[R-1]) begin
        rem_q[s+1] <= df;
        num_q[s+1] <= {num_q[s][W-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= sh;
        num_q[s+1] <= {num_q[s][W-2:0], 1'b0};
      end
    end
  end
  assign quo_o = num_q[W];
endmodule
`default_nettype wire

// ===== hw/rtl/irrigation_zone_decision_top.sv =====
// ----------------------------------------------------------------------------
// irrigation_zone_decision_top
// Zone valve decision from four tension readings, ET debt and runtime.
// ----------------------------------------------------------------------------
// Usage: busy is always low, so an item is taken on every cycle that
// start is high. Each item gives one result on done after these steps:
// the lane and adder-tree register at the accepting edge, 34 stages of
// the pipelined dividers (one quotient bit per stage, mean and depth side
// by side), then the decision logic into the output register. The receiver
// cannot stall, and results come in item order at up to one per cycle.
// Configuration writes are always ready and apply to items started after
// them.
`default_nettype none
module irrigation_zone_decision_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] psi_0_i,
  input  wire logic [15:0] psi_1_i,
  input  wire logic [15:0] psi_2_i,
  input  wire logic [15:0] psi_3_i,
  input  wire logic [15:0] et_debt_i,
  input  wire logic [16:0] elapsed_seconds_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             done,
  output logic             valve_on_o,
  output logic [1:0]       zone_state_o,
  output logic [2:0]       stop_reason_o,
  output logic [11:0]      psi_mean_o,
  output logic [15:0]      et_debt_out_o,
  output logic [15:0]      applied_depth_o
);
  localparam int Lat = izd_pkg::DivW;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration
  logic [11:0] mad_q;
  logic [15:0] flow_q, area_q;
  logic [1:0]  mode_q;
  logic [9:0]  w_q [izd_pkg::Sensors];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mad_q <= 12'd500; flow_q <= '0; area_q <= '0; mode_q <= izd_pkg::ModeManual;
      for (int i = 0; i < izd_pkg::Sensors; i++) w_q[i] <= 10'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        izd_pkg::RegMad:  mad_q  <= cfg_data_i[11:0];
        izd_pkg::RegFlow: flow_q <= cfg_data_i;
        izd_pkg::RegArea: area_q <= cfg_data_i;
        izd_pkg::RegMode: mode_q <= cfg_data_i[1:0];
        default: w_q[cfg_index_i[1:0]] <= cfg_data_i[9:0];
      endcase
    end
  end

  // lanes
  logic [15:0] psi [izd_pkg::Sensors];
  assign psi[0] = psi_0_i; assign psi[1] = psi_1_i;
  assign psi[2] = psi_2_i; assign psi[3] = psi_3_i;
  izd_pkg::lane_t lane [izd_pkg::Sensors];
  for (genvar g = 0; g < izd_pkg::Sensors; g++) begin : g_lane
    izd_lane u_lane (.psi_i(psi[g]), .weight_i(w_q[g]), .lane_o(lane[g]));
  end

  // merge: sums, counts, depth product
  logic [23:0] acc;
  logic [13:0] sum;
  logic [11:0] wsum;
  logic [2:0]  nval;
  always_comb begin
    acc = '0; sum = '0; wsum = '0; nval = '0;
    for (int i = 0; i < izd_pkg::Sensors; i++) begin
      if (lane[i].valid) begin
        acc  = acc + 24'(lane[i].prod);
        sum  = sum + 14'(lane[i].psi);
        wsum = wsum + 12'(w_q[i]);
        nval = nval + 3'd1;
      end
    end
  end

  // flow * seconds, 16 x 17 bits
  logic [32:0] dprod;
  assign dprod = 33'(flow_q) * 33'(elapsed_seconds_i);

  logic [izd_pkg::DivW-1:0] mnum_q, dnum_q;
  logic [izd_pkg::DsrW-1:0] mden_q, dden_q;
  izd_pkg::ctx_t ctx_in;
  logic v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    if (wsum != '0) begin
      mnum_q <= izd_pkg::DivW'(acc);
      mden_q <= izd_pkg::DsrW'(wsum);
    end else begin
      mnum_q <= izd_pkg::DivW'(sum);
      mden_q <= (nval == '0) ? izd_pkg::DsrW'(1) : izd_pkg::DsrW'(nval);
    end
    dnum_q <= izd_pkg::DivW'(dprod);
    // 36 * area as 32 * area + 4 * area
    dden_q <= (area_q == '0) ? izd_pkg::DsrW'(1) :
              izd_pkg::DsrW'({area_q, 5'b0}) + izd_pkg::DsrW'({area_q, 2'b0});
    ctx_in.fault    <= (3'(izd_pkg::Sensors) - nval) >= 3'd2;
    ctx_in.mode     <= mode_q;
    ctx_in.mad      <= mad_q;
    ctx_in.et       <= et_debt_i;
    ctx_in.elapsed  <= elapsed_seconds_i;
    ctx_in.depth_en <= (flow_q != '0) && (area_q != '0);
  end

  logic [izd_pkg::DivW-1:0] mq, dq;
  izd_div u_mdiv (.clk_i(clk_i), .num_i(mnum_q), .den_i(mden_q), .quo_o(mq));
  izd_div u_ddiv (.clk_i(clk_i), .num_i(dnum_q), .den_i(dden_q), .quo_o(dq));

  izd_pkg::ctx_t ctx_q [Lat];
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_in;
    for (int i = 1; i < Lat; i++) ctx_q[i] <= ctx_q[i-1];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[Lat-2:0], v1_q};
  end

  // decision
  izd_pkg::ctx_t c;
  logic [11:0] mean;
  logic [15:0] depth;
  logic        vo;
  logic [1:0]  zs;
  logic [2:0]  rs;
  logic [15:0] eo, dout;
  assign c = ctx_q[Lat-1];
  always_comb begin
    mean  = mq[11:0];
    depth = !c.depth_en ? 16'd0 : (dq > 34'hFFFF) ? 16'hFFFF : dq[15:0];
    vo = 1'b0; zs = izd_pkg::StIdle; rs = izd_pkg::RsNone; eo = c.et; dout = '0;
    if (c.fault) begin
      zs = izd_pkg::StFault; rs = izd_pkg::RsFault;
    end else if (c.mode == izd_pkg::ModeManual) begin
      rs = izd_pkg::RsManual;
    end else if (c.elapsed == '0) begin
      if (mean >= c.mad && !(c.mode == izd_pkg::ModeFull && c.et == '0)) begin
        vo = 1'b1; zs = izd_pkg::StIrrig; rs = izd_pkg::RsStart;
      end
    end else begin
      dout = depth;
      if (mean < c.mad) begin
        rs = izd_pkg::RsSoil; eo = '0;
      end else if (c.mode == izd_pkg::ModeFull && c.et != '0 && depth >= c.et) begin
        rs = izd_pkg::RsEt; eo = '0;
      end else if (c.elapsed >= 17'(izd_pkg::MaxRuntime)) begin
        rs = izd_pkg::RsRuntime; eo = '0;
      end else begin
        vo = 1'b1; zs = izd_pkg::StIrrig;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done <= 1'b0;
    else         done <= vld_q[Lat-1];
  end
  always_ff @(posedge clk_i) begin
    valve_on_o      <= vo;
    zone_state_o    <= zs;
    stop_reason_o   <= rs;
    psi_mean_o      <= mean;
    et_debt_out_o   <= eo;
    applied_depth_o <= dout;
  end

`include "assert_macros.svh"
  `AST_IMP(a_valve_state, clk_i, rst_ni, done && valve_on_o, zone_state_o == izd_pkg::StIrrig)
  `AST_IMP(a_fault_rs, clk_i, rst_ni, done && zone_state_o == izd_pkg::StFault,
           stop_reason_o == izd_pkg::RsFault && !valve_on_o)
  `AST_NXT(a_pipe, clk_i, rst_ni, vld_q[Lat-1], done)
endmodule
`default_nettype wire

// ===== bench/irrigation_zone_decision_top_test.sv =====
// ----------------------------------------------------------------------------
// irrigation_zone_decision_top_test
// Self-checking bench: directed table plus random items, scored in order
// against typed-in results or a bit-exact predictor of the zone decision.
// ----------------------------------------------------------------------------
`default_nettype none
module irrigation_zone_decision_top_test;
  import izd_pkg::*;

  localparam int LatencyCycles = 35;

  typedef struct {
    logic        valve;
    logic [1:0]  zstate;
    logic [2:0]  reason;
    logic [11:0] mean;
    logic [15:0] et_out;
    logic [15:0] depth;
  } decision_t;

  typedef struct {
    logic [15:0] psi [4];
    logic [15:0] et;
    logic [16:0] elapsed;
  } reading_t;

  // one row of the directed table; chk=1 means the typed result is used
  typedef struct {
    reading_t  rd;
    bit        chk;
    decision_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] psi_0_i = '0, psi_1_i = '0, psi_2_i = '0, psi_3_i = '0;
  logic [15:0] et_debt_i = '0;
  logic [16:0] elapsed_seconds_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        done;
  logic        valve_on_o;
  logic [1:0]  zone_state_o;
  logic [2:0]  stop_reason_o;
  logic [11:0] psi_mean_o;
  logic [15:0] et_debt_out_o, applied_depth_o;

  irrigation_zone_decision_top u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration registers.
  logic [11:0] mad_q;
  logic [15:0] flow_q, area_q;
  logic [1:0]  mode_q;
  logic [9:0]  wt_q [4];

  decision_t pending_q[$];
  int        fail_cnt = 0;
  int        idle_pct = 0;

  function automatic decision_t decide_zone(reading_t rd);
    decision_t d;
    longint    p;
    longint unsigned sum = 0, wsum = 0, acc = 0, mean = 0, depth = 0;
    int        nval = 0, ninv = 0;
    d = '{1'b0, StIdle, RsNone, 12'd0, rd.et, 16'd0};
    for (int i = 0; i < Sensors; i++) begin
      p = longint'($signed(rd.psi[i]));
      if (p >= PsiMin && p <= PsiMax) begin
        nval++;
        sum += p;
        wsum += wt_q[i];
        acc += p * wt_q[i];
      end else begin
        ninv++;
      end
    end
    if (wsum != 0) mean = acc / wsum;
    else if (nval != 0) mean = sum / nval;
    d.mean = mean[11:0];
    if (ninv >= 2) begin
      d.zstate = StFault;
      d.reason = RsFault;
    end else if (mode_q == ModeManual) begin
      d.reason = RsManual;
    end else if (rd.elapsed == 0) begin
      if (d.mean >= mad_q && !(mode_q == ModeFull && rd.et == 0)) begin
        d.valve = 1'b1;
        d.zstate = StIrrig;
        d.reason = RsStart;
      end
    end else begin
      if (flow_q != 0 && area_q != 0) begin
        depth = (longint'(flow_q) * rd.elapsed) / (36 * longint'(area_q));
        if (depth > 65535) depth = 65535;
      end
      d.depth = depth[15:0];
      if (d.mean < mad_q) begin
        d.reason = RsSoil;
        d.et_out = '0;
      end else if (mode_q == ModeFull && rd.et != 0 && depth >= rd.et) begin
        d.reason = RsEt;
        d.et_out = '0;
      end else if (rd.elapsed >= MaxRuntime) begin
        d.reason = RsRuntime;
        d.et_out = '0;
      end else begin
        d.valve = 1'b1;
        d.zstate = StIrrig;
      end
    end
    return d;
  endfunction

  // Valid drops for one cycle after each write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMad:  mad_q = val[11:0];
      RegFlow: flow_q = val;
      RegArea: area_q = val;
      RegMode: mode_q = val[1:0];
      default: wt_q[idx[1:0]] = val[9:0];
    endcase
    @(posedge clk_i);
  endtask

  // Presents one item; the predictor runs at acceptance so config is current.
  task automatic send_item(input reading_t rd, input bit chk, input decision_t res);
    decision_t exp_d;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    {psi_0_i, psi_1_i, psi_2_i, psi_3_i} <= {rd.psi[0], rd.psi[1], rd.psi[2], rd.psi[3]};
    et_debt_i <= rd.et;
    elapsed_seconds_i <= rd.elapsed;
    do @(posedge clk_i); while (busy);
    exp_d = chk ? res : decide_zone(rd);
    pending_q.push_back(exp_d);
  endtask

  // Lets all outstanding results drain before touching the config.
  task automatic drain;
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Readings mostly in range, occasionally out, to reach every branch.
  function automatic logic [15:0] rand_psi();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(2100, 1990));
      default: return 16'($urandom_range(PsiMax));
    endcase
  endfunction

  function automatic reading_t rand_reading();
    reading_t rd;
    foreach (rd.psi[i]) rd.psi[i] = rand_psi();
    rd.et = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom);
    case ($urandom_range(5))
      0:       rd.elapsed = '0;
      1:       rd.elapsed = 17'($urandom);
      2:       rd.elapsed = 17'($urandom_range(7210, 7190));
      default: rd.elapsed = 17'($urandom_range(7000));
    endcase
    return rd;
  endfunction

  // Result checker: strobe sampled at the edge, compared to the oldest entry.
  always @(posedge clk_i) begin
    decision_t e;
    if (rst_ni && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (valve_on_o !== e.valve) begin
          $error("valve_on exp %0d got %0d", e.valve, valve_on_o); fail_cnt++;
        end
        if (zone_state_o !== e.zstate) begin
          $error("zone_state exp %0d got %0d", e.zstate, zone_state_o); fail_cnt++;
        end
        if (stop_reason_o !== e.reason) begin
          $error("stop_reason exp %0d got %0d", e.reason, stop_reason_o); fail_cnt++;
        end
        if (psi_mean_o !== e.mean) begin
          $error("psi_mean exp %0d got %0d", e.mean, psi_mean_o); fail_cnt++;
        end
        if (et_debt_out_o !== e.et_out) begin
          $error("et_debt_out exp %0d got %0d", e.et_out, et_debt_out_o); fail_cnt++;
        end
        if (applied_depth_o !== e.depth) begin
          $error("applied_depth exp %0d got %0d", e.depth, applied_depth_o); fail_cnt++;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t      tbl[$];
    decision_t nd;
    reading_t  rd;
    logic [15:0] cfg_vals [8];
    nd = '{1'b0, StIdle, RsNone, 12'd0, 16'd0, 16'd0};

    mad_q = 12'd500; flow_q = '0; area_q = '0; mode_q = ModeManual;
    foreach (wt_q[i]) wt_q[i] = 10'd256;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: after reset (manual mode), typed-in results and one predicted ---
    tbl.push_back('{'{'{16'd1000, 16'd1000, 16'd1000, 16'd1000}, 16'd77, 17'd5}, 1,
                    '{1'b0, StIdle, RsManual, 12'd1000, 16'd77, 16'd0}});
    // two negative readings: fault
    tbl.push_back('{'{'{16'hFFFF, 16'h8000, 16'd10, 16'd20}, 16'hFFFF, 17'h1FFFF}, 1,
                    '{1'b0, StFault, RsFault, 12'd15, 16'hFFFF, 16'd0}});
    // all above range: fault, no valid mean
    tbl.push_back('{'{'{16'h7FFF, 16'd2001, 16'd2001, 16'h7FFF}, 16'd0, 17'd0}, 1,
                    '{1'b0, StFault, RsFault, 12'd0, 16'd0, 16'd0}});
    // one invalid only, extremes of range
    tbl.push_back('{'{'{16'd0, 16'd2000, 16'd2001, 16'd2000}, 16'd5, 17'd0}, 0, nd});
    foreach (tbl[i]) send_item(tbl[i].rd, tbl[i].chk, tbl[i].res);
    drain();

    // --- directed: soil-only auto, big flow, small area ---
    write_reg(RegMode, 16'd1);
    write_reg(RegFlow, 16'hFFFF);
    write_reg(RegArea, 16'd1);
    tbl.delete();
    tbl.push_back('{'{'{16'd600, 16'd600, 16'd600, 16'd600}, 16'd0, 17'd0}, 1,
                    '{1'b1, StIrrig, RsStart, 12'd600, 16'd0, 16'd0}});
    tbl.push_back('{'{'{16'd400, 16'd400, 16'd400, 16'd400}, 16'd9, 17'd0}, 0, nd});
    tbl.push_back('{'{'{16'd400, 16'd400, 16'd400, 16'd400}, 16'd9, 17'd100}, 0, nd});
    tbl.push_back('{'{'{16'd900, 16'd900, 16'd900, 16'd900}, 16'd9, 17'd7200}, 0, nd});
    tbl.push_back('{'{'{16'd900, 16'd900, 16'd900, 16'd900}, 16'd9, 17'd7199}, 0, nd});
    tbl.push_back('{'{'{16'd900, 16'd900, 16'd900, 16'd900}, 16'd9, 17'h1FFFF}, 0, nd});
    foreach (tbl[i]) send_item(tbl[i].rd, tbl[i].chk, tbl[i].res);
    drain();

    // --- directed: full auto, zero weights (plain mean), op_mode 3 later ---
    write_reg(RegMode, 16'd2);
    for (int i = 0; i < 4; i++) write_reg(RegW0 + 3'(i), 16'd0);
    write_reg(RegArea, 16'hFFFF);
    tbl.delete();
    tbl.push_back('{'{'{16'd700, 16'd800, 16'd900, 16'd1001}, 16'd0, 17'd0}, 0, nd});
    tbl.push_back('{'{'{16'd700, 16'd800, 16'd900, 16'd1001}, 16'd1, 17'd0}, 0, nd});
    tbl.push_back('{'{'{16'd700, 16'd800, 16'd900, 16'd1001}, 16'd1, 17'd3000}, 0, nd});
    tbl.push_back('{'{'{16'd700, 16'd800, 16'd900, 16'd1001}, 16'd0, 17'd3000}, 0, nd});
    foreach (tbl[i]) send_item(tbl[i].rd, tbl[i].chk, tbl[i].res);
    drain();
    write_reg(RegMode, 16'd3);
    write_reg(RegMad, 16'd4095);
    write_reg(RegW0, 16'd1023);
    for (int k = 0; k < 4; k++) send_item(rand_reading(), 0, nd);
    drain();

    // --- random phases: new settings per phase, varied sender idling ---
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      cfg_vals[0] = (ph == 1) ? 16'd0 : 16'($urandom_range(PsiMax + 100));
      cfg_vals[1] = (ph == 2) ? 16'd0 : ((ph == 3) ? 16'hFFFF : 16'($urandom));
      cfg_vals[2] = (ph == 4) ? 16'd0 : ((ph == 5) ? 16'd1 : 16'($urandom_range(5000, 1)));
      cfg_vals[3] = 16'($urandom_range(3));
      if (ph % 3 == 0) cfg_vals[3] = 16'($urandom_range(2, 1));
      for (int i = 4; i < 8; i++)
        cfg_vals[i] = (ph == 6) ? 16'hFFFF : 16'($urandom);
      for (int i = 0; i < 8; i++) write_reg(3'(i), cfg_vals[i]);
      for (int k = 0; k < 50; k++) begin
        rd = rand_reading();
        send_item(rd, 0, nd);
      end
      drain();
    end

    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
